>>> hw/rtl/wcc_pkg.sv
package wcc_pkg;

  localparam int unsigned NODE_SLOTS  = 1024;
  localparam int unsigned NODE_W      = $clog2(NODE_SLOTS);
  localparam int unsigned COUNT_W     = NODE_W + 1;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(NODE_SLOTS);

  typedef enum logic {
    KIND_EDGE  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic              in_range;
  } item_t;

  typedef struct packed {
    logic init_busy;
  } back_status_t;

  typedef enum logic [4:0] {
    ST_INIT   = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_WALK_A = 5'b00100,
    ST_WALK_B = 5'b01000,
    ST_PUT    = 5'b10000
  } back_state_e;

endpackage

>>> hw/rtl/weakly_connected_components_labeler_unit.sv
// Channel   Direction  Handshake                 Payload
// in        in         in_valid_i / in_stall_o    kind_i, node_a_i, node_b_i
// out       out        out_valid_o / out_stall_i  label_o, valid_res_o
// cfg       in         cfg_valid_i / cfg_ready_o  cfg_data_i (node_count)
//
// After reset a clearing pass sets each of the 1024 parent entries to its own id;
// in_stall_o stays high meanwhile.
// An edge walks node_a to its root, then node_b, and links the roots if they differ;
// a query walks node_a only. Each walk step waits on the registered parent RAM read.
// A four-entry queue lets the front take items while the back walks;
// out_stall_i holds the result register.
module weakly_connected_components_labeler_unit
  import wcc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               kind_i,
  input  logic [NODE_W-1:0]  node_a_i,
  input  logic [NODE_W-1:0]  node_b_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [NODE_W-1:0]  label_o,
  output logic               valid_res_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [COUNT_W-1:0] cfg_data_i
);

  back_status_t back_status;
  logic         q_push, q_pop, q_full, q_empty;
  item_t        q_in, q_out;

  wcc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .node_a_i     (node_a_i),
    .node_b_i     (node_b_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .back_status_i(back_status),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_item_o     (q_in)
  );

  wcc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (q_in),
    .pop_i  (q_pop),
    .item_o (q_out),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  wcc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_item_i     (q_out),
    .q_pop_o      (q_pop),
    .back_status_o(back_status),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .label_o      (label_o),
    .valid_res_o  (valid_res_o)
  );

endmodule

>>> hw/rtl/wcc_front.sv
module wcc_front
  import wcc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               kind_i,
  input  logic [NODE_W-1:0]  node_a_i,
  input  logic [NODE_W-1:0]  node_b_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [COUNT_W-1:0] cfg_data_i,
  input  back_status_t       back_status_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output item_t              q_item_o
);

  logic [COUNT_W-1:0] node_count_q, node_count_d;
  logic               a_ok, b_ok;

  assign cfg_ready_o  = 1'b1;
  assign node_count_d = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : node_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= COUNT_RESET;
    end else begin
      node_count_q <= node_count_d;
    end
  end

  assign a_ok = {1'b0, node_a_i} < node_count_q;
  assign b_ok = {1'b0, node_b_i} < node_count_q;

  assign in_stall_o = q_full_i | back_status_i.init_busy;

  always_comb begin
    q_item_o.kind     = kind_e'(kind_i);
    q_item_o.node_a   = node_a_i;
    q_item_o.node_b   = node_b_i;
    q_item_o.in_range = (kind_e'(kind_i) == KIND_QUERY) ? a_ok : (a_ok & b_ok);
  end

  // drop edges with an endpoint out of range
  assign q_push_o = in_valid_i & ~in_stall_o &
                    ((q_item_o.kind == KIND_QUERY) | q_item_o.in_range);

endmodule

>>> hw/rtl/wcc_queue.sv
module wcc_queue
  import wcc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  input  logic  pop_i,
  output item_t item_o,
  output logic  full_o,
  output logic  empty_o
);

  item_t             slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q, count_d;

  assign full_o  = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
  assign empty_o = count_q == '0;
  assign item_o  = slot_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    priority if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end else begin
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

>>> hw/rtl/wcc_ram.sv
module wcc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hw/rtl/wcc_back.sv
module wcc_back
  import wcc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  item_t             q_item_i,
  output logic              q_pop_o,
  output back_status_t      back_status_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [NODE_W-1:0] label_o,
  output logic              valid_res_o
);

  back_state_e       state_q, state_d;
  logic [NODE_W-1:0] init_cnt_q, init_cnt_d;
  logic [NODE_W-1:0] cur_q, cur_d;
  logic [NODE_W-1:0] ra_q, ra_d;
  logic [NODE_W-1:0] b_q, b_d;
  kind_e             kind_q, kind_d;
  logic [NODE_W-1:0] res_label_q, res_label_d;
  logic              res_valid_q, res_valid_d;
  logic              out_valid_q, out_valid_d;
  logic [NODE_W-1:0] label_q;
  logic              valid_res_q;
  logic              out_load;

  logic              we;
  logic [NODE_W-1:0] waddr, wdata, raddr, rdata;

  wcc_ram #(
    .WIDTH(NODE_W),
    .DEPTH(NODE_SLOTS)
  ) u_parent_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign back_status_o.init_busy = state_q == ST_INIT;

  always_comb begin
    state_d     = state_q;
    init_cnt_d  = init_cnt_q;
    cur_d       = cur_q;
    ra_d        = ra_q;
    b_d         = b_q;
    kind_d      = kind_q;
    res_label_d = res_label_q;
    res_valid_d = res_valid_q;
    q_pop_o     = 1'b0;
    out_load    = 1'b0;
    we          = 1'b0;
    waddr       = init_cnt_q;
    wdata       = init_cnt_q;
    raddr       = cur_q;
    unique case (state_q)
      ST_INIT: begin
        we         = 1'b1;
        init_cnt_d = init_cnt_q + 1'b1;
        if (init_cnt_q == NODE_W'(NODE_SLOTS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          kind_d  = q_item_i.kind;
          b_d     = q_item_i.node_b;
          cur_d   = q_item_i.node_a;
          raddr   = q_item_i.node_a;
          if (!q_item_i.in_range) begin
            res_label_d = '0;
            res_valid_d = 1'b0;
            state_d     = ST_PUT;
          end else begin
            state_d = ST_WALK_A;
          end
        end
      end
      ST_WALK_A: begin
        if (rdata == cur_q) begin
          if (kind_q == KIND_QUERY) begin
            res_label_d = cur_q;
            res_valid_d = 1'b1;
            state_d     = ST_PUT;
          end else begin
            ra_d    = cur_q;
            cur_d   = b_q;
            raddr   = b_q;
            state_d = ST_WALK_B;
          end
        end else begin
          cur_d = rdata;
          raddr = rdata;
        end
      end
      ST_WALK_B: begin
        if (rdata == cur_q) begin
          // hang the larger root under the smaller one
          priority if (ra_q < cur_q) begin
            we    = 1'b1;
            waddr = cur_q;
            wdata = ra_q;
          end else if (cur_q < ra_q) begin
            we    = 1'b1;
            waddr = ra_q;
            wdata = cur_q;
          end else begin
            we = 1'b0;
          end
          state_d = ST_IDLE;
        end else begin
          cur_d = rdata;
          raddr = rdata;
        end
      end
      ST_PUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  assign out_valid_d = out_load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      init_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_cnt_q  <= init_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    ra_q        <= ra_d;
    b_q         <= b_d;
    kind_q      <= kind_d;
    res_label_q <= res_label_d;
    res_valid_q <= res_valid_d;
    if (out_load) begin
      label_q     <= res_label_q;
      valid_res_q <= res_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign label_o     = label_q;
  assign valid_res_o = valid_res_q;

endmodule

>>> hw/rtl/wcc_checker.sv
module wcc_checker
  import wcc_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [NODE_W-1:0] label_o,
  input logic              valid_res_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(label_o) && $stable(valid_res_o))
    else $error("stalled result changed");

  a_invalid_label_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |-> label_o == '0)
    else $error("out-of-range query with nonzero label");

  a_clear_stalls: assert property (@(posedge clk_i)
    rst_ni && !$past(rst_ni) |-> in_stall_o && !out_valid_o)
    else $error("input taken during clearing pass");

endmodule

bind weakly_connected_components_labeler_unit wcc_checker u_wcc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .label_o    (label_o),
  .valid_res_o(valid_res_o)
);
